FILE: hdl/wildcard_word_match_counter_defines.svh
// ----------------------------------------------------------------------------
// Wildcard word match counter - assertion macros
// Property forms for the block that checks its own state.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_WORD_MATCH_COUNTER_DEFINES_SVH
`define WILDCARD_WORD_MATCH_COUNTER_DEFINES_SVH

// consequence must hold in the cycle after the trigger
`define WWMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// consequence must hold in the same cycle as the trigger
`define WWMC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/wwmc_pkg.sv
// ----------------------------------------------------------------------------
// wwmc_pkg
// Character codes, register indexes and helpers for the word match counter.
// ----------------------------------------------------------------------------
package wwmc_pkg;

    localparam int PATTERN_REG_COUNT = 4;
    localparam int PATTERN_BYTES     = 8 * PATTERN_REG_COUNT;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int LEN_REG_W         = 6;
    localparam int TOTAL_W           = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PAT_LOW      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_MID_LOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_MID_HIGH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_HIGH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT_LEN      = 3'd4;

    localparam logic [7:0] CHAR_QMARK   = 8'h3F;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef logic [PATTERN_BYTES*8-1:0] pattern_t;

    function automatic logic is_delim(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_COMMA, CHAR_PERIOD, CHAR_HYPHEN, CHAR_NEWLINE};
    endfunction

endpackage

FILE: hdl/wwmc_step.sv
// ----------------------------------------------------------------------------
// wwmc_step
// Active-position update for one text byte against the glob pattern.
// ----------------------------------------------------------------------------
module wwmc_step
    import wwmc_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  pattern_t                 pattern,
    input  logic [LEN_REG_W-1:0]     pattern_len,
    input  logic [PATTERN_MAX:0]     active,
    input  logic [7:0]               text_byte,
    output logic                     matched_now,
    output logic [PATTERN_MAX:0]     active_next
);

    localparam int POS    = PATTERN_MAX + 1;
    localparam int LEVELS = $clog2(POS);

    logic [PATTERN_MAX-1:0][7:0] pat_byte;
    logic [PATTERN_MAX-1:0]      star_v;
    logic [PATTERN_MAX-1:0]      hit_v;
    logic [POS-1:0]              lt_mask;
    logic [POS-1:0]              le_mask;
    logic [POS-1:0]              eq_mask;
    logic [POS-1:0]              closed;

    // bytes past the register file read as zero
    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++) begin : g_byte
            if (g < PATTERN_BYTES) begin : g_reg
                assign pat_byte[g] = pattern[g*8 +: 8];
            end else begin : g_zero
                assign pat_byte[g] = 8'h00;
            end
        end
    endgenerate

    always_comb begin
        int len_i;
        len_i = (int'(pattern_len) > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len);
        for (int i = 0; i < POS; i++) begin
            lt_mask[i] = (i < len_i);
            le_mask[i] = (i <= len_i);
            eq_mask[i] = (i == len_i);
        end
        for (int i = 0; i < PATTERN_MAX; i++) begin
            star_v[i] = (pat_byte[i] == CHAR_STAR);
            hit_v[i]  = (pat_byte[i] == CHAR_QMARK) || (pat_byte[i] == text_byte);
        end
    end

    // Empty-run closure of '*' as a parallel prefix: an active position
    // carries forward across the run of stars that directly follows it
    always_comb begin
        logic [POS-1:0] gen;
        logic [POS-1:0] prop;
        gen  = active & le_mask;
        prop = {star_v & lt_mask[PATTERN_MAX-1:0], 1'b0};
        for (int lvl = 0; lvl < LEVELS; lvl++) begin
            gen  = gen | (prop & (gen << (1 << lvl)));
            prop = prop & (prop << (1 << lvl));
        end
        closed = gen;
    end

    always_comb begin
        logic [PATTERN_MAX-1:0] live;
        logic [PATTERN_MAX-1:0] stay;
        logic [PATTERN_MAX-1:0] adv;
        live        = closed[PATTERN_MAX-1:0] & lt_mask[PATTERN_MAX-1:0];
        stay        = live & star_v;
        adv         = live & ~star_v & hit_v;
        active_next = {1'b0, stay} | {adv, 1'b0};
        matched_now = |(closed & eq_mask);
    end

endmodule

FILE: hdl/wildcard_word_match_counter.sv
// ----------------------------------------------------------------------------
// wildcard_word_match_counter
// Splits a byte stream into words and counts those matching a glob pattern.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  s_      | in        | s_tvalid / s_tready | tdata text_byte, tlast end_of_text
//  m_      | out       | m_tvalid / m_tready | tdata match_total, tuser
//          |           |                     | word_matched, tlast stream_done
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  The active-position update for each text byte is a single combinational
//  pass from the state registers into the state and result registers.
//  A word end or end of text loads the single result register; a new byte
//  is taken whenever that register is empty or is being drained.
//  Reset (aresetn low, synchronous) clears the pattern, the count and the
//  word state. cfg_ready is always high.
// ----------------------------------------------------------------------------
module wildcard_word_match_counter
    import wwmc_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] text_byte
    input  logic                   s_tlast,   // end_of_text
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TOTAL_W-1:0]     m_tdata,   // [31:0] match_total
    output logic                   m_tuser,   // [0] word_matched
    output logic                   m_tlast,   // stream_done
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "wildcard_word_match_counter_defines.svh"

    localparam int POS   = PATTERN_MAX + 1;
    localparam int EXT_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

    pattern_t               pattern_reg;
    logic [LEN_REG_W-1:0]   len_reg;
    logic [POS-1:0]         active_reg;
    logic                   inside_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   out_valid_reg;
    logic                   out_matched_reg;
    logic                   out_done_reg;

    logic                   s_accept;
    logic                   word_end;
    logic                   step_matched;
    logic                   word_matched;
    logic [POS-1:0]         step_active;
    logic [EXT_W-1:0]       cnt_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            len_reg     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PAT_LOW:      pattern_reg[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PAT_MID_LOW:  pattern_reg[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PAT_MID_HIGH: pattern_reg[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PAT_HIGH:     pattern_reg[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
                REG_PAT_LEN:      len_reg <= cfg_data[LEN_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    wwmc_step #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_step (
        .pattern     (pattern_reg),
        .pattern_len (len_reg),
        .active      (active_reg),
        .text_byte   (s_tdata),
        .matched_now (step_matched),
        .active_next (step_active)
    );

    assign s_tready     = !out_valid_reg || m_tready;
    assign s_accept     = s_tvalid && s_tready;
    // a delimiter only closes a word that is open
    assign word_end     = s_tlast || (is_delim(s_tdata) && inside_reg);
    assign word_matched = inside_reg && step_matched;
    assign cnt_next     = (word_matched && (cnt_reg != '1)) ? cnt_reg + 1'b1 : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= POS'(1);
            inside_reg <= 1'b0;
            cnt_reg    <= '0;
        end else if (s_accept) begin
            if (s_tlast || is_delim(s_tdata)) begin
                active_reg <= POS'(1);
                inside_reg <= 1'b0;
                if (word_end) begin
                    cnt_reg <= cnt_next;
                end
            end else begin
                active_reg <= step_active;
                inside_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept && word_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload follows the count register, so only the flags are held here
    always_ff @(posedge aclk) begin
        if (s_accept && word_end) begin
            out_matched_reg <= word_matched;
            out_done_reg    <= s_tlast;
        end
    end

    assign cnt_ext  = EXT_W'(cnt_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cnt_ext[TOTAL_W-1:0];
    assign m_tuser  = out_matched_reg;
    assign m_tlast  = out_done_reg;

    `WWMC_ASSERT_NEXT(a_eot_clears_word, aclk, aresetn,
        s_accept && s_tlast,
        !inside_reg && (active_reg == POS'(1)) && m_tvalid && m_tlast,
        "end of text did not close the word and raise a final result")
    `WWMC_ASSERT_NEXT(a_count_monotonic, aclk, aresetn,
        1'b1,
        cnt_reg >= $past(cnt_reg),
        "match count went backwards")
    `WWMC_ASSERT_NEXT(a_idle_count_holds, aclk, aresetn,
        !(s_accept && word_end),
        cnt_reg == $past(cnt_reg),
        "match count moved without a word end")
    `WWMC_ASSERT_NOW(a_match_needs_word, aclk, aresetn,
        word_matched,
        inside_reg && (active_reg != '0),
        "match reported with no live positions")

endmodule
